### rtl/ccf_pkg.sv
`default_nettype none

package ccf_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHECK_W = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CHECK_W-1:0] CHECK_POLY = 16'h1021;
  localparam logic [BYTE_W-1:0]  HDR_PAD    = 8'h00;

  // input item opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } ccf_op_t;

  // work queued from the front end to the back end
  typedef struct packed {
    ccf_op_t           kind;     // start of frame or payload byte
    logic [BYTE_W-1:0] value;    // command code or payload byte
    logic [BYTE_W-1:0] length;   // payload length (start only)
    logic              final_b;  // check follows this item
  } ccf_cmd_t;

  // queue status seen by the front end
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } ccf_qstat_t;

  // shift one byte, MSB first, into the running check
  function automatic logic [CHECK_W-1:0] check_feed(input logic [CHECK_W-1:0] c_in,
                                                    input logic [BYTE_W-1:0]  b);
    logic [CHECK_W-1:0] c;
    logic               top;
    c = c_in;
    for (int k = 0; k < BYTE_W; k++) begin
      top = c[CHECK_W-1];
      c   = {c[CHECK_W-2:0], 1'b0};
      if (top) begin
        c = c ^ CHECK_POLY;
      end
      c[0] = c[0] ^ b[BYTE_W-1-k];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/ccf_ifs.sv
`default_nettype none

// command input channel
interface ccf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ccf_pkg::BYTE_W-1:0] command;
  logic [ccf_pkg::BYTE_W-1:0] length;
  logic [ccf_pkg::BYTE_W-1:0] payload_byte;

  modport source (output valid, output op, output command, output length,
                  output payload_byte, input ready);
  modport sink   (input valid, input op, input command, input length,
                  input payload_byte, output ready);
endinterface

// framed byte output channel
interface ccf_out_if;
  logic                       valid;
  logic                       ready;
  logic [ccf_pkg::BYTE_W-1:0] out_byte;
  logic                       last_of_frame;

  modport source (output valid, output out_byte, output last_of_frame, input ready);
  modport sink   (input valid, input out_byte, input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/ccf_front.sv
`default_nettype none

module ccf_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ccf_in_if.sink                    in_chan,
  input  wire ccf_pkg::ccf_qstat_t  qstat,
  output logic                      push,
  output ccf_pkg::ccf_cmd_t         cmd
);

  logic [ccf_pkg::BYTE_W-1:0] bytes_left_r, bytes_left_nxt;
  logic                       accept;

  // take an item whenever the queue has room
  assign in_chan.ready = !qstat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // classify the item and track payload still owed to the open frame
  always_comb begin
    push           = 1'b0;
    cmd            = '0;
    bytes_left_nxt = bytes_left_r;
    if (accept) begin
      if (in_chan.op == ccf_pkg::OP_START) begin
        push           = 1'b1;
        cmd.kind       = ccf_pkg::OP_START;
        cmd.value      = in_chan.command;
        cmd.length     = in_chan.length;
        cmd.final_b    = (in_chan.length == '0);
        bytes_left_nxt = in_chan.length;
      end else if (bytes_left_r != '0) begin
        push           = 1'b1;
        cmd.kind       = ccf_pkg::OP_DATA;
        cmd.value      = in_chan.payload_byte;
        cmd.final_b    = (bytes_left_r == ccf_pkg::BYTE_W'(1));
        bytes_left_nxt = bytes_left_r - ccf_pkg::BYTE_W'(1);
      end
      // payload outside a frame is dropped
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/ccf_queue.sv
`default_nettype none

module ccf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ccf_pkg::ccf_cmd_t    push_cmd,
  input  wire logic                 pop,
  output ccf_pkg::ccf_cmd_t         head_cmd,
  output ccf_pkg::ccf_qstat_t       qstat
);

  ccf_pkg::ccf_cmd_t                 mem_r [ccf_pkg::QDEPTH];
  logic [ccf_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [ccf_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                              do_push, do_pop;

  assign qstat.full  = (count_r == ccf_pkg::QCNT_W'(ccf_pkg::QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign qstat.count = count_r;

  assign do_push  = push && !qstat.full;
  assign do_pop   = pop && !qstat.empty;
  assign head_cmd = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + ccf_pkg::QCNT_W'(1);
      2'b01:   count_nxt = count_r - ccf_pkg::QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + ccf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + ccf_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/ccf_back.sv
`default_nettype none

module ccf_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [ccf_pkg::BYTE_W-1:0] device_id,
  input  wire logic                       q_valid,
  input  wire ccf_pkg::ccf_cmd_t          q_cmd,
  output logic                            q_pop,
  ccf_out_if.source                       out_chan
);

  typedef enum logic [7:0] {
    BK_IDLE   = 8'b0000_0001,
    BK_HDR0   = 8'b0000_0010,
    BK_HDR1   = 8'b0000_0100,
    BK_HDR2   = 8'b0000_1000,
    BK_HDR3   = 8'b0001_0000,
    BK_DATA   = 8'b0010_0000,
    BK_CHK_LO = 8'b0100_0000,
    BK_CHK_HI = 8'b1000_0000
  } bk_state_t;

  bk_state_t                   state_r, state_nxt;
  ccf_pkg::ccf_cmd_t           cur_r, cur_nxt;
  logic [ccf_pkg::CHECK_W-1:0] check_r, check_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ccf_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        adv;
  logic                        done;
  logic                        emit;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.last_of_frame = out_last_r;

  // the output register is free or being emptied this cycle
  assign adv = !out_valid_r || out_chan.ready;

  // sequencer: one frame byte per cycle while the output register can advance
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    check_nxt    = check_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = 1'b0;
    emit         = 1'b0;
    done         = 1'b0;
    q_pop        = 1'b0;
    if (adv) begin
      unique case (state_r)
        BK_IDLE: begin
          done = 1'b1;
        end
        BK_HDR0: begin
          emit         = 1'b1;
          out_byte_nxt = device_id;
          check_nxt    = ccf_pkg::check_feed('0, device_id);
          state_nxt    = BK_HDR1;
        end
        BK_HDR1: begin
          emit         = 1'b1;
          out_byte_nxt = ccf_pkg::HDR_PAD;
          check_nxt    = ccf_pkg::check_feed(check_r, ccf_pkg::HDR_PAD);
          state_nxt    = BK_HDR2;
        end
        BK_HDR2: begin
          emit         = 1'b1;
          out_byte_nxt = cur_r.value;
          check_nxt    = ccf_pkg::check_feed(check_r, cur_r.value);
          state_nxt    = BK_HDR3;
        end
        BK_HDR3: begin
          emit         = 1'b1;
          out_byte_nxt = cur_r.length;
          check_nxt    = ccf_pkg::check_feed(check_r, cur_r.length);
          state_nxt    = BK_CHK_LO;
          done         = !cur_r.final_b;
        end
        BK_DATA: begin
          emit         = 1'b1;
          out_byte_nxt = cur_r.value;
          check_nxt    = ccf_pkg::check_feed(check_r, cur_r.value);
          state_nxt    = BK_CHK_LO;
          done         = !cur_r.final_b;
        end
        BK_CHK_LO: begin
          emit         = 1'b1;
          out_byte_nxt = check_r[ccf_pkg::BYTE_W-1:0];
          state_nxt    = BK_CHK_HI;
        end
        BK_CHK_HI: begin
          emit         = 1'b1;
          out_byte_nxt = check_r[ccf_pkg::CHECK_W-1:ccf_pkg::BYTE_W];
          out_last_nxt = 1'b1;
          done         = 1'b1;
        end
        default: begin
          state_nxt = BK_IDLE;
        end
      endcase

      // end of an item: pick up the next one without a gap
      if (done) begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_cmd;
          state_nxt = (q_cmd.kind == ccf_pkg::OP_START) ? BK_HDR0 : BK_DATA;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
    end
  end

  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      check_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      check_r     <= check_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv && emit) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/camera_command_framer_crc.sv
`default_nettype none

// Channel  Direction  Carries                              Handshake
// in_chan  in         op, command, length, payload_byte    valid/ready
// out_chan out        out_byte, last_of_frame              valid/ready
// cfg_*    in         device_id write data (cfg_data)      cfg_valid/cfg_ready
//
// The back end sends one frame byte per cycle unless out_chan stalls; a start item
// makes 4 bytes (6 with zero length), a payload item 1 (3 when it closes the frame).
// The front end takes an item in any cycle the 4-entry command queue has room.
// Restarting from empty, the back end passes through BK_IDLE without sending a byte.
// rst_n is synchronous; it clears the queue, the sequencer, the check and device_id.
// Either side may stall; the output byte sits in a register until taken.

module camera_command_framer_crc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ccf_in_if.sink                          in_chan,
  ccf_out_if.source                       out_chan,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ccf_pkg::BYTE_W-1:0] cfg_data
);

  logic [ccf_pkg::BYTE_W-1:0] device_id_r;
  ccf_pkg::ccf_qstat_t        qstat;
  ccf_pkg::ccf_cmd_t          push_cmd;
  ccf_pkg::ccf_cmd_t          head_cmd;
  logic                       push;
  logic                       pop;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      device_id_r <= cfg_data;
    end
  end

  ccf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .qstat   (qstat),
    .push    (push),
    .cmd     (push_cmd)
  );

  ccf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  ccf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .device_id (device_id_r),
    .q_valid   (!qstat.empty),
    .q_cmd     (head_cmd),
    .q_pop     (pop),
    .out_chan  (out_chan)
  );

  // queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= ccf_pkg::QCNT_W'(ccf_pkg::QDEPTH))
    else $error("command queue overfilled");

  // the front end only pushes into a queue with room
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into full queue");

  // the back end only pops an entry that is there
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
